// ===== design/mlt_pkg.sv =====
// Package for the multichannel loopback tester: sizes, codes and helper functions.
package mlt_pkg;

	localparam int CHANNELS    = 8;
	localparam int SAMPLE_BITS = 16;
	localparam int CH_W        = 3;
	localparam int CNT_W       = 14;
	localparam int CFG_AW      = 5;
	localparam int IN_DW       = 24;
	localparam int OUT_DW      = 16;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	typedef logic [CNT_W-1:0]       cnt_t;
	typedef logic [SAMPLE_BITS-1:0] level_t;

	typedef enum logic [1:0] {
		PH_ON       = 2'd0,
		PH_TURN_OFF = 2'd1,
		PH_OFF      = 2'd2,
		PH_TURN_ON  = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		V_NONE     = 3'd0,
		V_ON_PASS  = 3'd1,
		V_ON_FAIL  = 3'd2,
		V_OFF_PASS = 3'd3,
		V_OFF_FAIL = 3'd4
	} verdict_t;

	typedef enum logic [2:0] {
		R_ON_HIGH   = 3'd0,
		R_ON_LOW    = 3'd1,
		R_OFF_HIGH  = 3'd2,
		R_OFF_LOW   = 3'd3,
		R_SIG_LEN   = 3'd4,
		R_TRANS_LEN = 3'd5,
		R_ON_MIN    = 3'd6,
		R_OFF_MAX   = 3'd7
	} reg_idx_t;

	localparam level_t RST_ON_HIGH   = 16'd43200;
	localparam level_t RST_ON_LOW    = 16'd14400;
	localparam level_t RST_OFF_HIGH  = 16'd31104;
	localparam level_t RST_OFF_LOW   = 16'd26667;
	localparam cnt_t   RST_SIG_LEN   = 14'd10000;
	localparam cnt_t   RST_TRANS_LEN = 14'd1000;
	localparam cnt_t   RST_ON_MIN    = 14'd500;
	localparam cnt_t   RST_OFF_MAX   = 14'd50;

	// Saturating count step.
	function automatic cnt_t sat_inc(input cnt_t v);
		return (v == CNT_MAX) ? CNT_MAX : v + cnt_t'(1);
	endfunction

	// Staggered start: 1250 samples per channel index, saturated.
	function automatic cnt_t start_count(input int idx);
		int s;
		s = 1250 * idx;
		return (s > int'(CNT_MAX)) ? CNT_MAX : cnt_t'(s);
	endfunction

	// Odd channels start measuring the tone, even ones the quiet level.
	function automatic phase_t start_phase(input int idx);
		return (idx % 2 == 1) ? PH_ON : PH_OFF;
	endfunction

endpackage

// ===== design/multichannel_loopback_tester_core.sv =====
// Top level of the multichannel loopback tester: per-channel phase sequencer and grader.
//
//  channel   dir  handshake           payload
//  s_*       in   s_tvalid/s_tready   s_tdata: channel, sample
//  m_*       out  m_tvalid/m_tready   m_tdata: channel_echo, drive_tone, verdict, flags
//  apb       in   psel/penable/pready eight threshold, length and count registers
//
// One item a cycle sustained while the output is not stalled; each item passes the input
// stage and then waits in the output register, which drives m_tvalid.
// The per-channel state lives in flip-flops and is read and written in the same cycle
// as the item's result loads, so back-to-back items on one channel need no forwarding.
// Reset is asynchronous and puts every channel at its staggered start; no clearing pass.
// A stalled output holds its item; the input stage still takes one more item behind it.
module multichannel_loopback_tester_core (
	input  logic                      clk,
	input  logic                      arst_n,
	// slave stream
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [mlt_pkg::IN_DW-1:0] s_tdata,   // [2:0] channel, [18:3] sample
	// master stream
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [mlt_pkg::OUT_DW-1:0] m_tdata,  // [2:0] channel_echo, [3] drive_tone,
	                                             // [6:4] verdict, [7] ok_on_flag,
	                                             // [8] ok_off_flag, [9] all_passed
	// configuration
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [mlt_pkg::CFG_AW-1:0] paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready
);
	import mlt_pkg::*;

	localparam logic [CH_W:0] CH_LIMIT = (CH_W+1)'(CHANNELS);

	// configuration registers
	level_t on_high_q, on_low_q, off_high_q, off_low_q;
	cnt_t   sig_len_q, trans_len_q, on_min_q, off_max_q;

	// per-channel state
	phase_t phase_q    [CHANNELS];
	cnt_t   samples_q  [CHANNELS];
	cnt_t   high_q     [CHANNELS];
	cnt_t   low_q      [CHANNELS];
	logic   pass_on_q  [CHANNELS];
	logic   pass_off_q [CHANNELS];

	// input stage
	logic              valid_s1;
	logic [CH_W-1:0]   ch_s1;
	level_t            smp_s1;

	// output register
	logic              m_valid_q;
	logic [OUT_DW-1:0] m_data_q;
	logic [OUT_DW-1:0] out_word;

	logic     advance;
	logic     ch_ok;
	phase_t   ph_cur, ph_nxt;
	cnt_t     cnt_inc, high_inc, low_inc;
	level_t   thr_high, thr_low;
	cnt_t     len_sel;
	logic     is_signal, done;
	logic     on_ok, off_ok;
	logic     pass_on_nxt, pass_off_nxt;
	verdict_t verdict;
	logic     drive;
	logic     all_ok;
	reg_idx_t wr_idx, rd_idx;
	logic     cfg_wr;

	// ---------------------------------------------------------------- config port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;
	assign wr_idx = reg_idx_t'(paddr[4:2]);
	assign rd_idx = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_high_q   <= RST_ON_HIGH;
			on_low_q    <= RST_ON_LOW;
			off_high_q  <= RST_OFF_HIGH;
			off_low_q   <= RST_OFF_LOW;
			sig_len_q   <= RST_SIG_LEN;
			trans_len_q <= RST_TRANS_LEN;
			on_min_q    <= RST_ON_MIN;
			off_max_q   <= RST_OFF_MAX;
		end else if (cfg_wr) begin
			unique case (wr_idx)
				R_ON_HIGH:   on_high_q   <= pwdata[SAMPLE_BITS-1:0];
				R_ON_LOW:    on_low_q    <= pwdata[SAMPLE_BITS-1:0];
				R_OFF_HIGH:  off_high_q  <= pwdata[SAMPLE_BITS-1:0];
				R_OFF_LOW:   off_low_q   <= pwdata[SAMPLE_BITS-1:0];
				R_SIG_LEN:   sig_len_q   <= pwdata[CNT_W-1:0];
				R_TRANS_LEN: trans_len_q <= pwdata[CNT_W-1:0];
				R_ON_MIN:    on_min_q    <= pwdata[CNT_W-1:0];
				R_OFF_MAX:   off_max_q   <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (rd_idx)
			R_ON_HIGH:   prdata = 32'(on_high_q);
			R_ON_LOW:    prdata = 32'(on_low_q);
			R_OFF_HIGH:  prdata = 32'(off_high_q);
			R_OFF_LOW:   prdata = 32'(off_low_q);
			R_SIG_LEN:   prdata = 32'(sig_len_q);
			R_TRANS_LEN: prdata = 32'(trans_len_q);
			R_ON_MIN:    prdata = 32'(on_min_q);
			R_OFF_MAX:   prdata = 32'(off_max_q);
			default:     prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------- handshakes
	// Advance the input stage whenever the output register is empty or draining.
	assign advance  = valid_s1 & (~m_valid_q | m_tready);
	assign s_tready = ~valid_s1 | advance;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (s_tready) valid_s1 <= s_tvalid;
			m_valid_q <= advance | (m_valid_q & ~m_tready);
		end
	end

	// Payload registers: no reset.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			ch_s1  <= s_tdata[CH_W-1:0];
			smp_s1 <= s_tdata[CH_W +: SAMPLE_BITS];
		end
	end

	// ---------------------------------------------------------------- channel update
	assign ch_ok = {1'b0, ch_s1} < CH_LIMIT;

	always_comb begin
		ph_cur    = phase_q[ch_s1];
		cnt_inc   = sat_inc(samples_q[ch_s1]);
		is_signal = (ph_cur == PH_ON) || (ph_cur == PH_OFF);
		thr_high  = (ph_cur == PH_ON) ? on_high_q : off_high_q;
		thr_low   = (ph_cur == PH_ON) ? on_low_q  : off_low_q;
		len_sel   = is_signal ? sig_len_q : trans_len_q;

		// Count excursions only in the measuring phases.
		high_inc = (is_signal && smp_s1 > thr_high) ? sat_inc(high_q[ch_s1]) : high_q[ch_s1];
		low_inc  = (is_signal && smp_s1 < thr_low)  ? sat_inc(low_q[ch_s1])  : low_q[ch_s1];

		// A length of zero ends the phase on its first sample, as cnt_inc >= 1.
		done   = cnt_inc >= len_sel;
		on_ok  = (high_inc >= on_min_q) && (low_inc >= on_min_q);
		off_ok = (high_inc <= off_max_q) && (low_inc <= off_max_q);

		pass_on_nxt  = pass_on_q[ch_s1];
		pass_off_nxt = pass_off_q[ch_s1];
		verdict      = V_NONE;
		drive        = 1'b0;
		ph_nxt       = ph_cur;

		case (ph_cur)
			PH_ON: begin
				drive  = 1'b1;
				ph_nxt = PH_TURN_OFF;
				if (done) begin
					pass_on_nxt = on_ok;
					verdict     = on_ok ? V_ON_PASS : V_ON_FAIL;
				end
			end
			PH_OFF: begin
				drive  = 1'b0;
				ph_nxt = PH_TURN_ON;
				if (done) begin
					pass_off_nxt = off_ok;
					verdict      = off_ok ? V_OFF_PASS : V_OFF_FAIL;
				end
			end
			PH_TURN_OFF: begin
				drive  = 1'b0;
				ph_nxt = PH_OFF;
			end
			default: begin
				drive  = 1'b1;
				ph_nxt = PH_ON;
			end
		endcase

		// Every channel passing, with this item's flags folded in.
		all_ok = 1'b1;
		for (int i = 0; i < CHANNELS; i++) begin
			if (ch_ok && CH_W'(i) == ch_s1)
				all_ok = all_ok & pass_on_nxt & pass_off_nxt;
			else
				all_ok = all_ok & pass_on_q[i] & pass_off_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				phase_q[i]    <= start_phase(i);
				samples_q[i]  <= start_count(i);
				high_q[i]     <= '0;
				low_q[i]      <= '0;
				pass_on_q[i]  <= 1'b0;
				pass_off_q[i] <= 1'b0;
			end
		end else if (advance && ch_ok) begin
			pass_on_q[ch_s1]  <= pass_on_nxt;
			pass_off_q[ch_s1] <= pass_off_nxt;
			if (done) begin
				phase_q[ch_s1]   <= ph_nxt;
				samples_q[ch_s1] <= '0;
				high_q[ch_s1]    <= '0;
				low_q[ch_s1]     <= '0;
			end else begin
				samples_q[ch_s1] <= cnt_inc;
				high_q[ch_s1]    <= high_inc;
				low_q[ch_s1]     <= low_inc;
			end
		end
	end

	// Result word: unknown channels report nothing but the channel echo and the global flag.
	always_comb begin
		out_word = '0;
		out_word[CH_W-1:0] = ch_s1;
		out_word[9]        = all_ok;
		if (ch_ok) begin
			out_word[3]   = drive;
			out_word[6:4] = verdict;
			out_word[7]   = pass_on_nxt;
			out_word[8]   = pass_off_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			m_data_q <= out_word;
	end

	// ---------------------------------------------------------------- checks
	function automatic logic ch_ok_out(input logic [CH_W-1:0] c);
		return {1'b0, c} < CH_LIMIT;
	endfunction

	a_all_implies_own: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && m_data_q[9] && ch_ok_out(m_data_q[CH_W-1:0]) |-> m_data_q[7] && m_data_q[8])
		else $error("all_passed set while own flags clear");

	a_on_verdict_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && (m_data_q[6:4] == V_ON_PASS || m_data_q[6:4] == V_ON_FAIL)
		|-> m_data_q[7] == (m_data_q[6:4] == V_ON_PASS) && m_data_q[3])
		else $error("on verdict disagrees with flag or drive");

	a_off_verdict_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && (m_data_q[6:4] == V_OFF_PASS || m_data_q[6:4] == V_OFF_FAIL)
		|-> m_data_q[8] == (m_data_q[6:4] == V_OFF_PASS) && !m_data_q[3])
		else $error("off verdict disagrees with flag or drive");

	a_advance_loads: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_valid_q)
		else $error("advanced item lost before output register");

endmodule

// ===== bench/multichannel_loopback_tester_core_tb.sv =====
// Self-checking bench for the loopback tester core against a behavioral sequencer.
module multichannel_loopback_tester_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mlt_pkg::*;

	// Generous limit on the length of the run.
	localparam int CYCLE_LIMIT   = 1_500_000;
	// Margin of idle clocks before closing out.
	localparam int SETTLE_CYCLES = 8;
	localparam int LONG_HOLD     = 150;
	localparam int SETTINGS_RUN  = 6;
	localparam int ITEMS_PER_SET = 180;

	// One looped-back sample as offered on the slave stream.
	typedef struct {
		logic [CH_W-1:0] channel;
		level_t          sample;
	} loop_sample_t;

	// One result as it should leave the master stream.
	typedef struct {
		logic [CH_W-1:0] channel;
		logic            drive_tone;
		verdict_t        verdict;
		logic            ok_on;
		logic            ok_off;
		logic            all_passed;
	} channel_report_t;

	logic               clk      = 1'b0;
	logic               arst_n   = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [IN_DW-1:0]   s_tdata  = '0;   // [2:0] channel, [18:3] sample, [23:19] zero
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [OUT_DW-1:0]  m_tdata;         // [2:0] channel_echo, [3] drive_tone, [6:4] verdict,
	                                     // [7] ok_on_flag, [8] ok_off_flag, [9] all_passed
	logic               psel     = 1'b0;
	logic               penable  = 1'b0;
	logic               pwrite   = 1'b0;
	logic [CFG_AW-1:0]  paddr    = '0;
	logic [31:0]        pwdata   = '0;
	logic [31:0]        prdata;
	logic               pready;

	multichannel_loopback_tester_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Behavioral sequencer: its own copy of the per-channel state and of
	// the eight registers. It advances once per sample taken by the block.
	// ------------------------------------------------------------------
	phase_t ch_phase    [CHANNELS];
	cnt_t   ch_samples  [CHANNELS];
	cnt_t   ch_high     [CHANNELS];
	cnt_t   ch_low      [CHANNELS];
	logic   ch_pass_on  [CHANNELS];
	logic   ch_pass_off [CHANNELS];

	level_t lvl_on_high  = RST_ON_HIGH;
	level_t lvl_on_low   = RST_ON_LOW;
	level_t lvl_off_high = RST_OFF_HIGH;
	level_t lvl_off_low  = RST_OFF_LOW;
	cnt_t   len_signal     = RST_SIG_LEN;
	cnt_t   len_transition = RST_TRANS_LEN;
	cnt_t   min_on_count   = RST_ON_MIN;
	cnt_t   max_off_count  = RST_OFF_MAX;

	// Samples waiting to be offered, and results owed by the block, oldest first.
	loop_sample_t    sample_queue[$];
	channel_report_t channel_reports[$];

	int mismatches      = 0;
	int items_accepted  = 0;
	int results_checked = 0;
	int all_pass_items  = 0;
	int verdict_tally [5] = '{default: 0};

	// Counters stop at all ones instead of wrapping.
	function automatic cnt_t bump(cnt_t v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	// Move a channel on and clear its sample counter and both excursion counts.
	function automatic void enter_phase(int unsigned ch, phase_t ph);
		ch_phase[ch]   = ph;
		ch_samples[ch] = '0;
		ch_high[ch]    = '0;
		ch_low[ch]     = '0;
	endfunction

	function automatic logic every_channel_passed();
		logic ok;
		ok = 1'b1;
		for (int i = 0; i < CHANNELS; i++)
			if (!ch_pass_on[i] || !ch_pass_off[i])
				ok = 1'b0;
		return ok;
	endfunction

	// Advance one channel by one sample and return what the block must report.
	// Order: bump the sample counter, count the excursion, then compare with
	// the phase length. A length of zero ends the phase on its first sample,
	// which the >= compare gives for free.
	function automatic channel_report_t sequence_channel(loop_sample_t s);
		channel_report_t r;
		int unsigned     ch;
		logic            ok;
		ch           = s.channel;
		r.channel    = s.channel;
		r.drive_tone = 1'b0;
		r.verdict    = V_NONE;
		r.ok_on      = 1'b0;
		r.ok_off     = 1'b0;
		// A channel index past the last channel leaves all state alone.
		if (ch < CHANNELS) begin
			ch_samples[ch] = bump(ch_samples[ch]);
			case (ch_phase[ch])
				PH_ON: begin
					r.drive_tone = 1'b1;
					if (s.sample > lvl_on_high)
						ch_high[ch] = bump(ch_high[ch]);
					if (s.sample < lvl_on_low)
						ch_low[ch] = bump(ch_low[ch]);
					if (ch_samples[ch] >= len_signal) begin
						ok = (ch_high[ch] >= min_on_count) && (ch_low[ch] >= min_on_count);
						ch_pass_on[ch] = ok;
						r.verdict = ok ? V_ON_PASS : V_ON_FAIL;
						enter_phase(ch, PH_TURN_OFF);
					end
				end
				PH_OFF: begin
					r.drive_tone = 1'b0;
					if (s.sample > lvl_off_high)
						ch_high[ch] = bump(ch_high[ch]);
					if (s.sample < lvl_off_low)
						ch_low[ch] = bump(ch_low[ch]);
					if (ch_samples[ch] >= len_signal) begin
						ok = (ch_high[ch] <= max_off_count) && (ch_low[ch] <= max_off_count);
						ch_pass_off[ch] = ok;
						r.verdict = ok ? V_OFF_PASS : V_OFF_FAIL;
						enter_phase(ch, PH_TURN_ON);
					end
				end
				PH_TURN_OFF: begin
					r.drive_tone = 1'b0;
					if (ch_samples[ch] >= len_transition)
						enter_phase(ch, PH_OFF);
				end
				default: begin
					r.drive_tone = 1'b1;
					if (ch_samples[ch] >= len_transition)
						enter_phase(ch, PH_ON);
				end
			endcase
			r.ok_on  = ch_pass_on[ch];
			r.ok_off = ch_pass_off[ch];
		end
		r.all_passed = every_channel_passed();
		return r;
	endfunction

	// Mostly tone peaks, troughs and midscale rest, with exact thresholds,
	// rail values and a share of fully random levels mixed in.
	function automatic level_t pick_level();
		case ($urandom_range(0, 9))
			0, 1, 2: return level_t'($urandom_range(45000, 65535));
			3, 4, 5: return level_t'($urandom_range(0, 15000));
			6, 7:    return level_t'($urandom_range(25000, 32000));
			8: begin
				case ($urandom_range(0, 5))
					0:       return '0;
					1:       return '1;
					2:       return lvl_on_high;
					3:       return lvl_on_low;
					4:       return lvl_off_high;
					default: return lvl_off_low;
				endcase
			end
			default: return level_t'($urandom);
		endcase
	endfunction

	// Queue n samples on random channels, or all on one channel if only_channel >= 0.
	task automatic queue_samples(int n, int only_channel);
		loop_sample_t s;
		for (int i = 0; i < n; i++) begin
			s.channel = (only_channel < 0) ? CH_W'($urandom_range(0, CHANNELS - 1))
			                               : CH_W'(only_channel);
			s.sample  = pick_level();
			sample_queue.push_back(s);
		end
	endtask

	// Block until every queued sample is taken and every result has come back.
	// Look at the falling edge, where the driver's updates have settled.
	task automatic wait_idle();
		while (sample_queue.size() != 0 || s_tvalid || channel_reports.size() != 0)
			@(negedge clk);
	endtask

	// APB write: setup cycle, then access cycle; the register loads at the
	// edge that ends the access cycle. Bits above the register width carry
	// noise, which the block must drop.
	task automatic write_reg(reg_idx_t idx, logic [31:0] value);
		logic [31:0] word;
		word = $urandom;
		if (idx <= R_OFF_LOW)
			word[15:0] = value[15:0];
		else
			word[13:0] = value[13:0];
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= CFG_AW'(int'(idx) * 4);
		pwdata  <= word;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			R_ON_HIGH:   lvl_on_high    = word[15:0];
			R_ON_LOW:    lvl_on_low     = word[15:0];
			R_OFF_HIGH:  lvl_off_high   = word[15:0];
			R_OFF_LOW:   lvl_off_low    = word[15:0];
			R_SIG_LEN:   len_signal     = word[13:0];
			R_TRANS_LEN: len_transition = word[13:0];
			R_ON_MIN:    min_on_count   = word[13:0];
			default:     max_off_count  = word[13:0];
		endcase
	endtask

	// ------------------------------------------------------------------
	// Driver: offer items in bursts of random length separated by random
	// gaps. An offered item is held until the block takes it; the sequencer
	// advances at the very edge that accepts it.
	// ------------------------------------------------------------------
	int           burst_left;
	int           gap_left;
	loop_sample_t sent_sample;
	loop_sample_t next_sample;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid   <= 1'b0;
			s_tdata    <= '0;
			burst_left = 1;
			gap_left   = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				sent_sample.channel = s_tdata[CH_W-1:0];
				sent_sample.sample  = s_tdata[CH_W +: SAMPLE_BITS];
				channel_reports.push_back(sequence_channel(sent_sample));
				items_accepted++;
			end
			// Advance only when nothing is offered or the offer was just taken.
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (sample_queue.size() != 0) begin
					next_sample = sample_queue.pop_front();
					s_tdata  <= IN_DW'({next_sample.sample, next_sample.channel});
					s_tvalid <= 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 40);
						// Mostly short or no gaps, now and then a long one.
						gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12)
						                                        : $urandom_range(0, 2);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: stall on a pattern that switches between random modes
	// (always ready, coin flip, one cycle in four, rarely stalled). Once,
	// after about a hundred results, hold off for a long stretch so the
	// output register and input stage both fill and s_tready drops.
	// ------------------------------------------------------------------
	int   stall_mode;
	int   mode_left;
	int   hold_left;
	int   ready_tick;
	logic long_hold_done;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready       <= 1'b0;
			stall_mode     = 0;
			mode_left      = 0;
			hold_left      = 0;
			ready_tick     = 0;
			long_hold_done = 1'b0;
		end else begin
			ready_tick++;
			if (!long_hold_done && results_checked >= 100) begin
				long_hold_done = 1'b1;
				hold_left      = LONG_HOLD;
				m_tready       <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					stall_mode = $urandom_range(0, 3);
					mode_left  = $urandom_range(20, 120);
				end else begin
					mode_left--;
				end
				case (stall_mode)
					0:       m_tready <= 1'b1;
					1:       m_tready <= 1'($urandom_range(0, 1));
					2:       m_tready <= (ready_tick % 4 == 0);
					default: m_tready <= ($urandom_range(0, 9) != 0);
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: compare every result, field by field, with the oldest one owed.
	// ------------------------------------------------------------------
	channel_report_t awaited;

	function automatic void compare_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= 40)
				$display("%0t ns: %s mismatch, expected %0d, actual %0d",
				         $time, name, want, got);
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (channel_reports.size() == 0) begin
				mismatches++;
				if (mismatches <= 40)
					$display("%0t ns: result with nothing owed, expected none, actual m_tdata %h",
					         $time, m_tdata);
			end else begin
				awaited = channel_reports.pop_front();
				compare_field("channel_echo", awaited.channel, m_tdata[2:0]);
				compare_field("drive_tone", awaited.drive_tone, m_tdata[3]);
				compare_field("verdict", int'(awaited.verdict), m_tdata[6:4]);
				compare_field("ok_on_flag", awaited.ok_on, m_tdata[7]);
				compare_field("ok_off_flag", awaited.ok_off, m_tdata[8]);
				compare_field("all_passed", awaited.all_passed, m_tdata[9]);
				verdict_tally[int'(awaited.verdict)]++;
				if (awaited.all_passed)
					all_pass_items++;
			end
			results_checked <= results_checked + 1;
		end
	end

	// Hard stop in case the block hangs.
	int cycle_count = 0;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("multichannel_loopback_tester_core regression: fail");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Test sequence.
	// ------------------------------------------------------------------
	initial begin
		int           start_samples;
		loop_sample_t s;

		// Staggered start: odd channels measure the tone, even ones the rest
		// level, and each channel is 1250 samples further into its phase.
		for (int i = 0; i < CHANNELS; i++) begin
			start_samples  = 1250 * i;
			ch_phase[i]    = (i % 2 == 1) ? PH_ON : PH_OFF;
			ch_samples[i]  = (start_samples > 16383) ? cnt_t'('1) : cnt_t'(start_samples);
			ch_high[i]     = '0;
			ch_low[i]      = '0;
			ch_pass_on[i]  = 1'b0;
			ch_pass_off[i] = 1'b0;
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Under reset settings: both rails and an exact threshold on every channel.
		for (int ch = 0; ch < CHANNELS; ch++) begin
			s.channel = CH_W'(ch);
			s.sample  = '0;
			sample_queue.push_back(s);
			s.sample  = '1;
			sample_queue.push_back(s);
			s.sample  = (ch % 2 == 1) ? lvl_on_high : lvl_off_low;
			sample_queue.push_back(s);
		end
		wait_idle();

		for (int setting = 0; setting < SETTINGS_RUN; setting++) begin
			case (setting)
				0: begin
					// Shortest phases: a verdict every other sample per channel.
					write_reg(R_SIG_LEN, 1);
					write_reg(R_TRANS_LEN, 1);
					write_reg(R_ON_MIN, 0);
					write_reg(R_OFF_MAX, 0);
				end
				1: begin
					// Realistic thresholds, short phases, small count limits.
					write_reg(R_ON_HIGH, 43200);
					write_reg(R_ON_LOW, 14400);
					write_reg(R_OFF_HIGH, 31104);
					write_reg(R_OFF_LOW, 26667);
					write_reg(R_SIG_LEN, $urandom_range(8, 16));
					write_reg(R_TRANS_LEN, $urandom_range(1, 3));
					write_reg(R_ON_MIN, $urandom_range(2, 4));
					write_reg(R_OFF_MAX, $urandom_range(0, 2));
				end
				2: begin
					// Every grade passes, so all channels end up passing together.
					write_reg(R_ON_HIGH, 0);
					write_reg(R_ON_LOW, 16'hffff);
					write_reg(R_ON_MIN, 0);
					write_reg(R_OFF_MAX, 16383);
					write_reg(R_SIG_LEN, $urandom_range(2, 5));
					write_reg(R_TRANS_LEN, $urandom_range(1, 2));
				end
				3: begin
					write_reg(R_ON_HIGH, $urandom_range(0, 65535));
					write_reg(R_ON_LOW, $urandom_range(0, 65535));
					write_reg(R_OFF_HIGH, $urandom_range(0, 65535));
					write_reg(R_OFF_LOW, $urandom_range(0, 65535));
					write_reg(R_SIG_LEN, $urandom_range(2, 10));
					write_reg(R_TRANS_LEN, $urandom_range(1, 6));
					write_reg(R_ON_MIN, $urandom_range(0, 5));
					write_reg(R_OFF_MAX, $urandom_range(0, 5));
				end
				4: begin
					// Low threshold above the high one: one sample can count both ways.
					write_reg(R_ON_HIGH, $urandom_range(0, 30000));
					write_reg(R_ON_LOW, $urandom_range(35000, 65535));
					write_reg(R_OFF_HIGH, $urandom_range(20000, 28000));
					write_reg(R_OFF_LOW, $urandom_range(29000, 40000));
					write_reg(R_SIG_LEN, $urandom_range(4, 12));
					write_reg(R_ON_MIN, $urandom_range(1, 6));
					write_reg(R_OFF_MAX, $urandom_range(1, 6));
				end
				default: begin
					write_reg(R_ON_HIGH, RST_ON_HIGH);
					write_reg(R_ON_LOW, RST_ON_LOW);
					write_reg(R_OFF_HIGH, RST_OFF_HIGH);
					write_reg(R_OFF_LOW, RST_OFF_LOW);
					write_reg(R_SIG_LEN, $urandom_range(1, 20));
					write_reg(R_TRANS_LEN, $urandom_range(1, 20));
					write_reg(R_ON_MIN, $urandom_range(0, 8));
					write_reg(R_OFF_MAX, $urandom_range(0, 8));
				end
			endcase
			queue_samples(ITEMS_PER_SET, -1);
			wait_idle();
		end

		// Then short phases again: the rest level with no excursions allowed.
		write_reg(R_OFF_MAX, 0);
		write_reg(R_SIG_LEN, 2);
		queue_samples(40, -1);
		wait_idle();

		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Run covered %0d samples on %0d channels, %0d results checked,",
		         items_accepted, CHANNELS, results_checked);
		$display("verdicts %0d/%0d tone pass/fail, %0d/%0d rest pass/fail, %0d all passing.",
		         verdict_tally[V_ON_PASS], verdict_tally[V_ON_FAIL], verdict_tally[V_OFF_PASS],
		         verdict_tally[V_OFF_FAIL], all_pass_items);
		if (mismatches == 0 && channel_reports.size() == 0) begin
			$display("multichannel_loopback_tester_core regression: pass");
		end else begin
			$display("multichannel_loopback_tester_core regression: fail");
		end
		$finish;
	end

endmodule

// ===== multichannel_loopback_tester_core.f =====
design/mlt_pkg.sv
design/multichannel_loopback_tester_core.sv
bench/multichannel_loopback_tester_core_tb.sv
